[design/dtq_pkg.sv]
package dtq_pkg;

    // Slot store geometry.
    localparam int TIMER_SLOTS = 32;
    localparam int SLOT_W      = $clog2(TIMER_SLOTS);
    localparam int CNT_W       = $clog2(TIMER_SLOTS + 1);
    localparam int DL_W        = 48;
    localparam int NOW_W       = 47;
    localparam int DELAY_W     = 32;
    localparam int LIMIT_W     = 7;

    // Port field widths.
    localparam int OP_W     = 2;
    localparam int KIND_W   = 2;
    localparam int OSLOT_W  = 5;
    localparam int OCOUNT_W = 6;
    localparam int LEFT_W   = 32;

    localparam logic [LIMIT_W-1:0] RUN_LIMIT_RESET = LIMIT_W'(64);
    localparam logic [LEFT_W-1:0]  LEFT_MAX        = 32'h7FFF_FFFF;
    localparam logic [LEFT_W-1:0]  LEFT_NONE       = 32'hFFFF_FFFF;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_RUN    = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd3;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_ACK      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN_DONE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY    = 2'd3;

    // Running minimum kept by the scan unit.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] idx;
        logic [DL_W-1:0]   dl;
    } t_best;

endpackage

[design/dtq_ram.sv]
module dtq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/dtq_scan.sv]
module dtq_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_sample,
    input  logic [dtq_pkg::SLOT_W-1:0] i_idx,
    input  logic [dtq_pkg::DL_W-1:0]   i_dl,
    output dtq_pkg::t_best             o_best
);

    dtq_pkg::t_best r_best;

    // Slots arrive in ascending order, so a strict compare keeps the lower slot on ties.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best.found <= 1'b0;
        end else if (i_clear) begin
            r_best.found <= 1'b0;
        end else if (i_sample && (!r_best.found || i_dl < r_best.dl)) begin
            r_best.found <= 1'b1;
            r_best.idx   <= i_idx;
            r_best.dl    <= i_dl;
        end
    end

    assign o_best = r_best;

endmodule

[design/deadline_timer_queue.sv]
// Deadline timer queue: a set of timer slots with absolute deadlines in ms.
// Input channel (i_valid/o_ready) carries one operation per transaction: add
// or update a slot, delete a slot, run expiries, or query the earliest deadline.
// Output channel (o_valid/i_ready) returns the results; o_last marks the final
// result of each operation. A run returns one result per expired slot and then
// a run-finished result with the count.
// One operation is worked at a time; o_ready is high only between operations.
// Add and delete: the execute state updates the slot and loads the acknowledge.
// Query and each run step: the deadline memory is swept through its single
// read port, one slot per cycle; a drain state for the registered read and
// a decide state follow before each result is loaded.
// A single output register holds each result; when the receiver stalls, the
// block waits with the next result until that register is taken.
// The run limit register is written through i_cfg_we/i_cfg_run_limit; a zero
// write is ignored. Reset disarms all slots, clears the armed count and sets
// the run limit to 64. Deadline entries need no clearing pass since only
// armed slots are ever sampled.
module deadline_timer_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [dtq_pkg::LIMIT_W-1:0]   i_cfg_run_limit,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [dtq_pkg::OP_W-1:0]      i_operation,
    input  logic [4:0]                    i_timer_slot,
    input  logic [dtq_pkg::DELAY_W-1:0]   i_delay_ms,
    input  logic [dtq_pkg::NOW_W-1:0]     i_now_ms,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dtq_pkg::KIND_W-1:0]    o_kind,
    output logic [dtq_pkg::OSLOT_W-1:0]   o_expired_slot,
    output logic [dtq_pkg::OCOUNT_W-1:0]  o_expired_count,
    output logic signed [dtq_pkg::LEFT_W-1:0] o_time_left,
    output logic [dtq_pkg::OCOUNT_W-1:0]  o_active_count,
    output logic                          o_last
);

    localparam int SLOTS  = dtq_pkg::TIMER_SLOTS;
    localparam int SLOT_W = dtq_pkg::SLOT_W;
    localparam int CNT_W  = dtq_pkg::CNT_W;
    localparam int DL_W   = dtq_pkg::DL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_DRAIN,
        S_DECIDE
    } t_state;

    t_state r_state;

    // Latched transaction.
    logic [dtq_pkg::OP_W-1:0]    r_op;
    logic [4:0]                  r_slot;
    logic [dtq_pkg::DELAY_W-1:0] r_delay;
    logic [dtq_pkg::NOW_W-1:0]   r_now;

    // Sweep and bookkeeping.
    logic [SLOT_W-1:0]           r_idx;
    logic                        r_rd_valid;
    logic [SLOT_W-1:0]           r_rd_idx;
    logic [CNT_W-1:0]            r_cnt;
    logic [CNT_W-1:0]            r_total;
    logic [SLOTS-1:0]            r_armed;
    logic [dtq_pkg::LIMIT_W-1:0] r_run_limit;

    // Output register.
    logic                           r_o_valid;
    logic [dtq_pkg::KIND_W-1:0]     r_o_kind;
    logic [dtq_pkg::OSLOT_W-1:0]    r_o_slot;
    logic [dtq_pkg::OCOUNT_W-1:0]   r_o_count;
    logic [dtq_pkg::LEFT_W-1:0]     r_o_left;
    logic [dtq_pkg::OCOUNT_W-1:0]   r_o_active;
    logic                           r_o_last;

    logic              out_free;
    logic              out_load;
    logic              slot_ok;
    logic [SLOT_W-1:0] slot_a;
    logic              ram_we;
    logic [DL_W-1:0]   ram_wdata;
    logic [DL_W-1:0]   ram_rdata;
    logic              scan_clear;
    logic              scan_sample;
    dtq_pkg::t_best    best;
    logic              due;
    logic              limit_ok;
    logic              expire;
    logic [DL_W-1:0]   diff;
    logic [dtq_pkg::LEFT_W-1:0] left;
    logic              add_new;
    logic              del_hit;

    // Decode of the latched transaction.
    always_comb begin
        out_free    = !r_o_valid || i_ready;
        out_load    = out_free && (((r_state == S_EXEC) && ((r_op == dtq_pkg::OP_ADD) ||
                      (r_op == dtq_pkg::OP_DELETE))) || (r_state == S_DECIDE));
        slot_ok     = (32'(r_slot) < SLOTS);
        slot_a      = SLOT_W'(r_slot);
        add_new     = (r_op == dtq_pkg::OP_ADD) && slot_ok && !r_armed[slot_a];
        del_hit     = (r_op == dtq_pkg::OP_DELETE) && slot_ok && r_armed[slot_a];
        ram_we      = (r_state == S_EXEC) && out_free && (r_op == dtq_pkg::OP_ADD) && slot_ok;
        ram_wdata   = DL_W'(r_now) + DL_W'(r_delay);
        // The swept minimum is kept until its result has been loaded.
        scan_clear  = (r_state == S_EXEC) || ((r_state == S_DECIDE) && out_free);
        scan_sample = r_rd_valid && r_armed[r_rd_idx];
    end

    // Verdict on the swept minimum.
    always_comb begin
        due      = best.found && (best.dl <= DL_W'(r_now));
        limit_ok = (32'(r_cnt) < 32'(r_run_limit)) && (32'(r_cnt) < SLOTS);
        expire   = (r_op == dtq_pkg::OP_RUN) && limit_ok && due;
        diff     = best.dl - DL_W'(r_now);
        if (!best.found) begin
            left = dtq_pkg::LEFT_NONE;
        end else if (due) begin
            left = '0;
        end else if (diff > DL_W'(dtq_pkg::LEFT_MAX)) begin
            left = dtq_pkg::LEFT_MAX;
        end else begin
            left = diff[dtq_pkg::LEFT_W-1:0];
        end
    end

    dtq_ram #(
        .WIDTH (DL_W),
        .DEPTH (SLOTS)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (slot_a),
        .i_wdata (ram_wdata),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    dtq_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (scan_clear),
        .i_sample (scan_sample),
        .i_idx    (r_rd_idx),
        .i_dl     (ram_rdata),
        .o_best   (best)
    );

    // Controller, armed flags and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_armed     <= '0;
            r_total     <= '0;
            r_run_limit <= dtq_pkg::RUN_LIMIT_RESET;
            r_o_valid   <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            if (i_cfg_we && (i_cfg_run_limit != '0)) begin
                r_run_limit <= i_cfg_run_limit;
            end
            r_rd_valid <= (r_state == S_SCAN);
            r_rd_idx   <= r_idx;
            if (out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_operation;
                        r_slot  <= i_timer_slot;
                        r_delay <= i_delay_ms;
                        r_now   <= i_now_ms;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (r_op == dtq_pkg::OP_ADD || r_op == dtq_pkg::OP_DELETE) begin
                        if (out_free) begin
                            if (add_new) begin
                                r_armed[slot_a] <= 1'b1;
                                r_total         <= r_total + 1'b1;
                            end else if (del_hit) begin
                                r_armed[slot_a] <= 1'b0;
                                r_total         <= r_total - 1'b1;
                            end
                            r_o_kind   <= dtq_pkg::KIND_ACK;
                            r_o_slot   <= '0;
                            r_o_count  <= '0;
                            r_o_left   <= '0;
                            r_o_active <= dtq_pkg::OCOUNT_W'(add_new ? r_total + 1'b1 :
                                          del_hit ? r_total - 1'b1 : r_total);
                            r_o_last   <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end else begin
                        r_idx   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_idx == SLOT_W'(SLOTS - 1)) begin
                        r_state <= S_DRAIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (out_free) begin
                        if (r_op == dtq_pkg::OP_QUERY) begin
                            r_o_kind   <= dtq_pkg::KIND_QUERY;
                            r_o_slot   <= '0;
                            r_o_count  <= '0;
                            r_o_left   <= left;
                            r_o_active <= dtq_pkg::OCOUNT_W'(r_total);
                            r_o_last   <= 1'b1;
                            r_state    <= S_IDLE;
                        end else if (expire) begin
                            // Disarm the earliest due slot and sweep again.
                            r_armed[best.idx] <= 1'b0;
                            r_total           <= r_total - 1'b1;
                            r_cnt             <= r_cnt + 1'b1;
                            r_o_kind          <= dtq_pkg::KIND_EXPIRED;
                            r_o_slot          <= dtq_pkg::OSLOT_W'(best.idx);
                            r_o_count         <= '0;
                            r_o_left          <= '0;
                            r_o_active        <= dtq_pkg::OCOUNT_W'(r_total - 1'b1);
                            r_o_last          <= 1'b0;
                            r_idx             <= '0;
                            r_state           <= S_SCAN;
                        end else begin
                            r_o_kind   <= dtq_pkg::KIND_RUN_DONE;
                            r_o_slot   <= '0;
                            r_o_count  <= dtq_pkg::OCOUNT_W'(r_cnt);
                            r_o_left   <= '0;
                            r_o_active <= dtq_pkg::OCOUNT_W'(r_total);
                            r_o_last   <= 1'b1;
                            r_state    <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready         = (r_state == S_IDLE);
    assign o_valid         = r_o_valid;
    assign o_kind          = r_o_kind;
    assign o_expired_slot  = r_o_slot;
    assign o_expired_count = r_o_count;
    assign o_time_left     = r_o_left;
    assign o_active_count  = r_o_active;
    assign o_last          = r_o_last;

endmodule

[design/dtq_checker.sv]
module dtq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_ready,
    input logic                          o_valid,
    input logic                          i_ready,
    input logic [dtq_pkg::KIND_W-1:0]    o_kind,
    input logic signed [dtq_pkg::LEFT_W-1:0] o_time_left,
    input logic [dtq_pkg::OCOUNT_W-1:0]  o_active_count,
    input logic                          o_last
);

    // A stalled result transaction holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_kind) && $stable(o_last))
        else $error("result changed while stalled");

    // One operation at a time: acceptance closes the input side.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input accepted while an operation is in progress");

    // Only an expiry result leaves the operation open.
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last == (o_kind != dtq_pkg::KIND_EXPIRED)))
        else $error("last flag disagrees with result kind");

    // Armed count never exceeds the slot count.
    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (32'(o_active_count) <= dtq_pkg::TIMER_SLOTS))
        else $error("active count out of range");

    // Time left is reported by query answers only.
    a_left_query_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind != dtq_pkg::KIND_QUERY) |-> (o_time_left == '0))
        else $error("time left set on a non-query result");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (.*);
